>>> hw/rtl/dsbox_pkg.sv
// shared constants, register indexes and sigmoid table for the detection decode unit
package dsbox_pkg;

    localparam int ScoreW       = 16;
    localparam int CoordW       = 16;
    localparam int SizeW        = 15;
    localparam int OffW         = 10;
    localparam int ScaleW       = 16;
    localparam int ClassCntW    = 8;
    localparam int LabelW       = 9;
    localparam int AnchorW      = 14;
    localparam int EdgeW        = 14;
    localparam int ExtW         = 13;
    localparam int ConfW        = 8;
    localparam int InDataW      = 80;
    localparam int OutDataW     = 88;
    localparam int CfgIndexW    = 2;
    localparam int CfgDataW     = 16;

    localparam logic [ClassCntW-1:0] ClassCntMax  = '1;
    localparam logic [AnchorW-1:0]   AnchorCntMax = '1;

    localparam logic signed [ScoreW-1:0] StartScore   = -16'sd28160;
    localparam logic signed [LabelW-1:0] NoClass      = '1;
    localparam logic [ScaleW-1:0]        InvScaleInit = 16'd4096;

    // saturation limit of the sigmoid input, 6.0 in Q8.8
    localparam logic [ScoreW-1:0]        SigSatMag    = 16'd1536;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_CONF_THRESHOLD = 2'd0,
        CFG_X_OFFSET       = 2'd1,
        CFG_Y_OFFSET       = 2'd2,
        CFG_INV_SCALE      = 2'd3
    } cfg_index_t;

    // 65536 * sigmoid(k / 2), rounded
    function automatic logic [15:0] sig_tab(input logic [3:0] k);
        logic [15:0] v;
        case (k)
            4'd0:    v = 16'd32768;
            4'd1:    v = 16'd40793;
            4'd2:    v = 16'd47911;
            4'd3:    v = 16'd53581;
            4'd4:    v = 16'd57724;
            4'd5:    v = 16'd60565;
            4'd6:    v = 16'd62428;
            4'd7:    v = 16'd63615;
            4'd8:    v = 16'd64357;
            4'd9:    v = 16'd64816;
            4'd10:   v = 16'd65097;
            4'd11:   v = 16'd65269;
            4'd12:   v = 16'd65374;
            default: v = 16'd65374;
        endcase
        return v;
    endfunction

endpackage

>>> hw/rtl/detection_score_argmax_box_decode_unit.sv
// detection head decode: per-anchor class argmax, threshold and letterbox box decode
//
// s_axis carries one class logit per transfer; tuser marks the last class of an
// anchor and tlast the last transfer of a frame. box fields are sampled only on
// the last class. a running maximum and its class index are updated in the
// transfer cycle; on the last class, if the maximum beats conf_threshold, one
// detection enters a three-register pipeline (candidate, products, result)
// and m_axis_tvalid rises when it reaches the result register.
// the input takes one transfer per cycle while s_axis_tready is high, as the
// argmax registers compare and update on each transfer; anchors that emit
// nothing leave no gap. the cfg port writes conf_threshold, x_offset,
// y_offset and inv_scale; write only while no detection is in flight.
// reset clears the argmax, class and anchor counters and loads register
// defaults (inv_scale 1.0). when m_axis_tready is low the result register holds
// and the pipeline fills; s_axis_tready falls only once all three stages hold
// a detection, so the input keeps flowing across a short stall.
module detection_score_argmax_box_decode_unit
    import dsbox_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // class_score, box_cx, box_cy, box_w, box_h, zero pad
    input  logic [InDataW-1:0]   s_axis_tdata,
    // last_anchor
    input  logic                 s_axis_tlast,
    // last_class
    input  logic [0:0]           s_axis_tuser,
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // left, top, width, height, label, confidence, anchor_index, zero pad
    output logic [OutDataW-1:0]  m_axis_tdata,
    input  logic                 cfg_we,
    input  logic [CfgIndexW-1:0] cfg_index,
    input  logic [CfgDataW-1:0]  cfg_data
);

    // configuration
    logic signed [ScoreW-1:0] conf_threshold_reg;
    logic [OffW-1:0]          x_offset_reg;
    logic [OffW-1:0]          y_offset_reg;
    logic [ScaleW-1:0]        inv_scale_reg;

    // argmax state
    logic signed [ScoreW-1:0] best_score_reg;
    logic signed [LabelW-1:0] best_class_reg;
    logic [ClassCntW-1:0]     class_count_reg;
    logic [AnchorW-1:0]       anchor_count_reg;

    // candidate stage
    logic                     s1_valid_reg;
    logic signed [17:0]       s1_x5_reg;
    logic signed [17:0]       s1_y5_reg;
    logic [SizeW-1:0]         s1_w_reg;
    logic [SizeW-1:0]         s1_h_reg;
    logic signed [LabelW-1:0] s1_label_reg;
    logic [ScoreW-1:0]        s1_score_reg;
    logic [AnchorW-1:0]       s1_anchor_reg;

    // product stage
    logic                     s2_valid_reg;
    logic signed [34:0]       s2_px_reg;
    logic signed [34:0]       s2_py_reg;
    logic [30:0]              s2_pw_reg;
    logic [30:0]              s2_ph_reg;
    logic signed [LabelW-1:0] s2_label_reg;
    logic [15:0]              s2_base_reg;
    logic [12:0]              s2_frac_reg;
    logic                     s2_sat_reg;
    logic                     s2_neg_reg;
    logic [AnchorW-1:0]       s2_anchor_reg;

    // result register
    logic                     out_valid_reg;
    logic [EdgeW-1:0]         out_left_reg;
    logic [EdgeW-1:0]         out_top_reg;
    logic [ExtW-1:0]          out_width_reg;
    logic [ExtW-1:0]          out_height_reg;
    logic [LabelW-1:0]        out_label_reg;
    logic [ConfW-1:0]         out_conf_reg;
    logic [AnchorW-1:0]       out_anchor_reg;

    logic out_ready;
    logic s2_ready;
    logic s1_ready;
    logic in_xfer;

    assign out_ready     = !out_valid_reg || m_axis_tready;
    assign s2_ready      = !s2_valid_reg || out_ready;
    assign s1_ready      = !s1_valid_reg || s2_ready;
    assign s_axis_tready = s1_ready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    // input fields
    logic signed [ScoreW-1:0] in_score;
    logic signed [CoordW-1:0] in_cx;
    logic signed [CoordW-1:0] in_cy;
    logic [SizeW-1:0]         in_w;
    logic [SizeW-1:0]         in_h;
    logic                     in_last_class;
    logic                     in_last_anchor;

    assign in_score       = s_axis_tdata[15:0];
    assign in_cx          = s_axis_tdata[31:16];
    assign in_cy          = s_axis_tdata[47:32];
    assign in_w           = s_axis_tdata[62:48];
    assign in_h           = s_axis_tdata[77:63];
    assign in_last_class  = s_axis_tuser[0];
    assign in_last_anchor = s_axis_tlast;

    // argmax update and threshold
    logic                     better;
    logic signed [ScoreW-1:0] cand_score;
    logic signed [LabelW-1:0] cand_class;
    logic                     emit;
    logic signed [17:0]       x5;
    logic signed [17:0]       y5;

    always_comb
    begin
        better     = in_score > best_score_reg;
        cand_score = better ? in_score : best_score_reg;
        cand_class = better ? {1'b0, class_count_reg} : best_class_reg;
        emit       = in_last_class && (cand_score > conf_threshold_reg);
        // corner in Q.5: 2*centre - size - offset
        x5 = {in_cx[15], in_cx, 1'b0} - {3'b000, in_w} - {3'b000, x_offset_reg, 5'b00000};
        y5 = {in_cy[15], in_cy, 1'b0} - {3'b000, in_h} - {3'b000, y_offset_reg, 5'b00000};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            conf_threshold_reg <= '0;
            x_offset_reg       <= '0;
            y_offset_reg       <= '0;
            inv_scale_reg      <= InvScaleInit;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                CFG_CONF_THRESHOLD: conf_threshold_reg <= cfg_data;
                CFG_X_OFFSET:       x_offset_reg       <= cfg_data[OffW-1:0];
                CFG_Y_OFFSET:       y_offset_reg       <= cfg_data[OffW-1:0];
                CFG_INV_SCALE:      inv_scale_reg      <= cfg_data;
                default:            ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_score_reg   <= StartScore;
            best_class_reg   <= NoClass;
            class_count_reg  <= '0;
            anchor_count_reg <= '0;
        end
        else if (in_xfer)
        begin
            if (in_last_anchor || in_last_class)
            begin
                best_score_reg  <= StartScore;
                best_class_reg  <= NoClass;
                class_count_reg <= '0;
            end
            else
            begin
                best_score_reg <= cand_score;
                best_class_reg <= cand_class;
                if (class_count_reg != ClassCntMax)
                begin
                    class_count_reg <= class_count_reg + 1'b1;
                end
            end
            if (in_last_anchor)
            begin
                anchor_count_reg <= '0;
            end
            else if (in_last_class && (anchor_count_reg != AnchorCntMax))
            begin
                anchor_count_reg <= anchor_count_reg + 1'b1;
            end
        end
    end

    // candidate stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s1_ready)
        begin
            s1_valid_reg <= in_xfer && emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer && emit)
        begin
            s1_x5_reg     <= x5;
            s1_y5_reg     <= y5;
            s1_w_reg      <= in_w;
            s1_h_reg      <= in_h;
            s1_label_reg  <= cand_class;
            s1_score_reg  <= cand_score;
            s1_anchor_reg <= anchor_count_reg;
        end
    end

    // products and sigmoid table lookup
    logic signed [34:0] px;
    logic signed [34:0] py;
    logic [30:0]        pw;
    logic [30:0]        ph;
    logic [15:0]        mag;
    logic [3:0]         seg;
    logic [6:0]         fr;
    logic [15:0]        t_lo;
    logic [15:0]        t_hi;
    logic [15:0]        t_diff;
    logic [19:0]        t_prod;

    always_comb
    begin
        px     = s1_x5_reg * $signed({1'b0, inv_scale_reg});
        py     = s1_y5_reg * $signed({1'b0, inv_scale_reg});
        pw     = 31'(s1_w_reg) * 31'(inv_scale_reg);
        ph     = 31'(s1_h_reg) * 31'(inv_scale_reg);
        mag    = s1_score_reg[15] ? (~s1_score_reg + 16'd1) : s1_score_reg;
        seg    = mag[10:7];
        fr     = mag[6:0];
        t_lo   = sig_tab(seg);
        t_hi   = sig_tab(seg + 4'd1);
        t_diff = t_hi - t_lo;
        t_prod = 20'(t_diff[12:0]) * 20'(fr);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg <= 1'b0;
        end
        else if (s2_ready)
        begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_ready && s1_valid_reg)
        begin
            s2_px_reg     <= px;
            s2_py_reg     <= py;
            s2_pw_reg     <= pw;
            s2_ph_reg     <= ph;
            s2_label_reg  <= s1_label_reg;
            s2_base_reg   <= t_lo;
            s2_frac_reg   <= t_prod[19:7];
            s2_sat_reg    <= mag >= SigSatMag;
            s2_neg_reg    <= s1_score_reg[15];
            s2_anchor_reg <= s1_anchor_reg;
        end
    end

    // truncation toward zero, saturation and confidence
    logic signed [34:0] px_adj;
    logic signed [34:0] py_adj;
    logic signed [17:0] rx;
    logic signed [17:0] ry;
    logic [EdgeW-1:0]   left_next;
    logic [EdgeW-1:0]   top_next;
    logic [ExtW-1:0]    width_next;
    logic [ExtW-1:0]    height_next;
    logic [16:0]        f;
    logic [16:0]        f_inv;
    logic [ConfW-1:0]   conf_next;

    always_comb
    begin
        px_adj = s2_px_reg[34] ? (s2_px_reg + 35'sd131071) : s2_px_reg;
        py_adj = s2_py_reg[34] ? (s2_py_reg + 35'sd131071) : s2_py_reg;
        rx     = px_adj[34:17];
        ry     = py_adj[34:17];

        if (rx > 18'sd8191)
            left_next = 14'h1fff;
        else if (rx < -18'sd8192)
            left_next = 14'h2000;
        else
            left_next = rx[EdgeW-1:0];

        if (ry > 18'sd8191)
            top_next = 14'h1fff;
        else if (ry < -18'sd8192)
            top_next = 14'h2000;
        else
            top_next = ry[EdgeW-1:0];

        width_next  = (s2_pw_reg[30:16] > 15'd8191) ? 13'h1fff : s2_pw_reg[28:16];
        height_next = (s2_ph_reg[30:16] > 15'd8191) ? 13'h1fff : s2_ph_reg[28:16];

        f     = s2_sat_reg ? 17'h10000 : ({1'b0, s2_base_reg} + 17'(s2_frac_reg));
        f_inv = 17'h10000 - f;
        if (s2_neg_reg)
            conf_next = f_inv[15:8];
        else if (f[16])
            conf_next = 8'hff;
        else
            conf_next = f[15:8];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_ready)
        begin
            out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_ready && s2_valid_reg)
        begin
            out_left_reg   <= left_next;
            out_top_reg    <= top_next;
            out_width_reg  <= width_next;
            out_height_reg <= height_next;
            out_label_reg  <= s2_label_reg;
            out_conf_reg   <= conf_next;
            out_anchor_reg <= s2_anchor_reg;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {3'b000, out_anchor_reg, out_conf_reg, out_label_reg,
                            out_height_reg, out_width_reg, out_top_reg, out_left_reg};

    // no class index recorded means the maximum is still the start score
    assert property (@(posedge clk) disable iff (!rst_n)
        (best_class_reg == NoClass) |-> (best_score_reg == StartScore))
        else $error("argmax class cleared but score moved");

    // recorded class never lies beyond the classes seen so far
    assert property (@(posedge clk) disable iff (!rst_n)
        !best_class_reg[LabelW-1] |-> (best_class_reg[ClassCntW-1:0] <= class_count_reg))
        else $error("argmax class beyond class count");

    // an empty result register always lets input through
    assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_axis_tready)
        else $error("input stalled with empty result register");

    // a stalled product stage keeps its detection
    assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s2_ready) |=> s2_valid_reg)
        else $error("detection dropped in product stage");

endmodule
